[rtl/swia_pkg.sv]
// Package for the SIMT warp integer ALU: sizes, codes and shared types.
`default_nettype none
package swia_pkg;
    localparam int LANES = 32;
    localparam int NUM_REGS = 32;
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int REG_W = $clog2(NUM_REGS);
    localparam int SEL_PC = 32;

    typedef enum logic [1:0] {
        REQ_EXEC  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [4:0] {
        OP_ADDPC = 5'd0, OP_ADDI = 5'd1, OP_SLTI = 5'd2, OP_SLTI_U = 5'd3,
        OP_XORI = 5'd4, OP_ORI = 5'd5, OP_ANDI = 5'd6, OP_SLLI = 5'd7,
        OP_SRLI = 5'd8, OP_SRAI = 5'd9, OP_ADD = 5'd10, OP_SUB = 5'd11,
        OP_SLL = 5'd12, OP_SLT = 5'd13, OP_SLTU = 5'd14, OP_XOR = 5'd15,
        OP_SRL = 5'd16, OP_SRA = 5'd17, OP_OR = 5'd18, OP_AND = 5'd19,
        OP_MUL = 5'd20, OP_MULH = 5'd21, OP_MULH_SU = 5'd22, OP_MULH_UU = 5'd23,
        OP_DIV = 5'd24, OP_DIVU = 5'd25, OP_REM = 5'd26, OP_REMU = 5'd27,
        OP_BAD0 = 5'd28, OP_BAD1 = 5'd29, OP_BAD2 = 5'd30, OP_BAD3 = 5'd31
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FETCH, ST_CALC, ST_DIVIDE, ST_WRITE, ST_DONE
    } t_state;

    // Lane control from the sequencer.
    typedef struct packed {
        logic       start;  // operands registered, begin work
        logic [4:0] op;
        logic [31:0] imm;
    } t_lane_ctl;
endpackage
`default_nettype wire

[rtl/swia_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module swia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/swia_lane.sv]
// One lane's ALU: the plain ops and the multiply, plus a radix-2 divider.
`default_nettype none
module swia_lane (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire swia_pkg::t_lane_ctl   i_ctl,
    input  wire logic [31:0]           i_a,
    input  wire logic [31:0]           i_b,
    input  wire logic [31:0]           i_pc,
    output logic      [31:0]           o_result,
    output logic                       o_done
);
    import swia_pkg::*;

    logic [31:0] r_a, r_b, r_pc, r_imm, r_res;
    logic [4:0]  r_op;
    logic        r_busy, r_div, r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_quo, r_rem, r_dvd, r_dvs;
    logic        r_negq, r_negr, r_zero;
    logic [63:0] r_prod;
    logic        r_mulstage;

    logic [31:0] n_res, ma, mb;
    logic [32:0] trial;
    logic        is_div, sgn;
    logic [31:0] a_corr, b_corr, hi;

    always_comb begin
        is_div = (r_op == OP_DIV) || (r_op == OP_DIVU) ||
                 (r_op == OP_REM) || (r_op == OP_REMU);
        sgn = (r_op == OP_DIV) || (r_op == OP_REM);
        ma = (sgn && r_a[31]) ? 32'(0 - r_a) : r_a;
        mb = (sgn && r_b[31]) ? 32'(0 - r_b) : r_b;
        trial = {r_rem, r_dvd[31]} - {1'b0, r_dvs};
        a_corr = ((r_op == OP_MULH) || (r_op == OP_MULH_SU)) && r_a[31] ? r_b : '0;
        b_corr = (r_op == OP_MULH) && r_b[31] ? r_a : '0;
        hi = r_prod[63:32] - a_corr - b_corr;
        n_res = '0;
        case (r_op)
            OP_ADDPC:  n_res = r_pc + r_imm;
            OP_ADDI:   n_res = r_a + r_imm;
            OP_SLTI:   n_res = {31'd0, $signed(r_a) < $signed(r_imm)};
            OP_SLTI_U: n_res = {31'd0, r_a < r_imm};
            OP_XORI:   n_res = r_a ^ r_imm;
            OP_ORI:    n_res = r_a | r_imm;
            OP_ANDI:   n_res = r_a & r_imm;
            OP_SLLI:   n_res = r_a << r_imm[4:0];
            OP_SRLI:   n_res = r_a >> r_imm[4:0];
            OP_SRAI:   n_res = 32'($signed(r_a) >>> r_imm[4:0]);
            OP_ADD:    n_res = r_a + r_b;
            OP_SUB:    n_res = r_a - r_b;
            OP_SLL:    n_res = r_a << r_b[4:0];
            OP_SLT:    n_res = {31'd0, $signed(r_a) < $signed(r_b)};
            OP_SLTU:   n_res = {31'd0, r_a < r_b};
            OP_XOR:    n_res = r_a ^ r_b;
            OP_SRL:    n_res = r_a >> r_b[4:0];
            OP_SRA:    n_res = 32'($signed(r_a) >>> r_b[4:0]);
            OP_OR:     n_res = r_a | r_b;
            OP_AND:    n_res = r_a & r_b;
            OP_MUL:    n_res = r_prod[31:0];
            OP_MULH, OP_MULH_SU, OP_MULH_UU: n_res = hi;
            default:   n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_div <= 1'b0;
            r_mulstage <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_a <= i_a; r_b <= i_b; r_pc <= i_pc;
                r_imm <= i_ctl.imm; r_op <= i_ctl.op;
                r_busy <= 1'b1; r_div <= 1'b0; r_mulstage <= 1'b0;
            end else if (r_busy && !r_div && !r_mulstage) begin
                // Operands are registered; multiply first, then pick the result.
                r_prod <= 64'(r_a) * 64'(r_b);
                if (is_div) begin
                    r_div <= 1'b1;
                    r_dvd <= ma; r_dvs <= mb; r_rem <= '0; r_quo <= '0;
                    r_cnt <= 6'd32;
                    r_zero <= (r_b == '0);
                    r_negq <= sgn && (r_a[31] ^ r_b[31]);
                    r_negr <= sgn && r_a[31];
                end else begin
                    r_mulstage <= 1'b1;
                end
            end else if (r_busy && r_mulstage) begin
                r_res <= n_res;
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else if (r_busy && r_div) begin
                if (r_cnt != 6'd0) begin
                    r_cnt <= r_cnt - 6'd1;
                    r_dvd <= {r_dvd[30:0], 1'b0};
                    if (!trial[32]) begin
                        r_rem <= trial[31:0];
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[30:0], r_dvd[31]};
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                end else begin
                    if ((r_op == OP_DIV) || (r_op == OP_DIVU))
                        r_res <= r_zero ? 32'hFFFF_FFFF :
                                 (r_negq ? 32'(0 - r_quo) : r_quo);
                    else
                        r_res <= r_zero ? r_a : (r_negr ? 32'(0 - r_rem) : r_rem);
                    r_busy <= 1'b0;
                    r_div <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_result = r_res;
    assign o_done = r_done;
endmodule
`default_nettype wire

[rtl/swia_lane_bank.sv]
// Register file and pc store of one lane, with the lane's ALU.
`default_nettype none
module swia_lane_bank (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire swia_pkg::t_lane_ctl   i_ctl,
    input  wire logic [swia_pkg::REG_W-1:0] i_raddr1,
    input  wire logic [swia_pkg::REG_W-1:0] i_raddr2,
    input  wire logic                  i_a_zero,
    input  wire logic                  i_b_zero,
    input  wire logic                  i_reg_we,
    input  wire logic [swia_pkg::REG_W-1:0] i_waddr,
    input  wire logic [31:0]           i_wdata,
    input  wire logic                  i_pc_we,
    input  wire logic [31:0]           i_pc_wdata,
    output logic      [31:0]           o_rd1,
    output logic      [31:0]           o_pc,
    output logic      [31:0]           o_result,
    output logic                       o_done
);
    import swia_pkg::*;

    logic [31:0] r_pc;
    logic [31:0] rd2, alu_a, alu_b;

    swia_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf1 (
        .i_clk, .i_we(i_reg_we), .i_waddr, .i_wdata, .i_raddr(i_raddr1), .o_rdata(o_rd1));
    swia_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf2 (
        .i_clk, .i_we(i_reg_we), .i_waddr, .i_wdata, .i_raddr(i_raddr2), .o_rdata(rd2));

    // Source index zero or out of range reads as zero.
    assign alu_a = i_a_zero ? '0 : o_rd1;
    assign alu_b = i_b_zero ? '0 : rd2;

    always_ff @(posedge i_clk) begin
        if (i_pc_we) r_pc <= i_pc_wdata;
    end
    assign o_pc = r_pc;

    swia_lane u_alu (
        .i_clk, .i_rst_n, .i_ctl, .i_a(alu_a), .i_b(alu_b), .i_pc(r_pc),
        .o_result, .o_done);
endmodule
`default_nettype wire

[rtl/simt_warp_integer_alu.sv]
// Top level of the SIMT warp integer ALU: request sequencer and lane array.
`default_nettype none
// A request beat is taken only when the block is idle and its result register
// is empty, so one request is in flight at a time; its single result beat is
// held in an output register until taken. For a register write or read the
// sequencer passes through FETCH and DONE before the result beat is registered.
// An execute request with a legal op runs all enabled lanes in parallel through
// FETCH, CALC, DIVIDE, WRITE and DONE; for div, divu, rem and remu the DIVIDE
// state lasts as long as each lane's bit-serial divider (one quotient bit per cycle,
// 32 steps). The next request can be accepted at the clock edge after the one
// that takes the result beat. Each lane keeps its registers in two RAM copies
// so both source operands are read in the same cycle. Registers and counters are
// undefined until written, except x0, which always reads zero.
module simt_warp_integer_alu (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_active_mask,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [4:0]  i_op,
    input  wire logic [4:0]  i_dest_reg,
    input  wire logic [4:0]  i_src1_reg,
    input  wire logic [4:0]  i_src2_reg,
    input  wire logic [31:0] i_immediate,
    input  wire logic [4:0]  i_lane_sel,
    input  wire logic [5:0]  i_reg_sel,
    input  wire logic [31:0] i_write_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_read_data,
    output logic             o_illegal
);
    import swia_pkg::*;

    t_state r_state, n_state;
    logic [31:0] r_mask;
    logic [1:0]  r_req;
    logic [4:0]  r_op, r_rd, r_rs1, r_rs2, r_lane;
    logic [5:0]  r_sel;
    logic [31:0] r_imm, r_wval;
    logic        r_ovalid;
    logic [31:0] r_odata;
    logic        r_oill;

    logic [31:0] rd1 [LANES];
    logic [31:0] pcs [LANES];
    logic [31:0] res [LANES];
    logic [LANES-1:0] done;
    logic [LANES-1:0] reg_we, pc_we;
    logic [REG_W-1:0] raddr1, raddr2, waddr;
    logic [31:0] wdata [LANES];
    logic [31:0] pc_wd [LANES];
    t_lane_ctl ctl;

    logic in_acc, lane_ok, sel_reg_ok, rd_ok, op_bad, d_lane, a_zero, b_zero;

    assign in_acc = i_valid && o_ready;
    assign o_ready = (r_state == ST_IDLE) && !r_ovalid;
    assign o_cfg_ready = 1'b1;
    assign lane_ok = (32'(r_lane) < LANES);
    assign sel_reg_ok = (r_sel != '0) && (32'(r_sel) < NUM_REGS);
    assign rd_ok = (r_rd != '0) && (32'(r_rd) < NUM_REGS);
    assign op_bad = (r_op == OP_BAD0) || (r_op == OP_BAD1) ||
                    (r_op == OP_BAD2) || (r_op == OP_BAD3);
    // Every lane runs the same op and so finishes in the same cycle.
    assign d_lane = &done;
    assign a_zero = (r_rs1 == '0) || (32'(r_rs1) >= NUM_REGS);
    assign b_zero = (r_rs2 == '0) || (32'(r_rs2) >= NUM_REGS);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_acc) n_state = ST_FETCH;
            ST_FETCH:  n_state = (r_req == REQ_EXEC && !op_bad) ? ST_CALC : ST_DONE;
            ST_CALC:   n_state = ST_DIVIDE;
            ST_DIVIDE: if (d_lane) n_state = ST_WRITE;
            ST_WRITE:  n_state = ST_DONE;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs toward the lanes.
    always_comb begin
        raddr1 = (r_req == REQ_EXEC) ? REG_W'(r_rs1) : REG_W'(r_sel);
        raddr2 = REG_W'(r_rs2);
        waddr = (r_req == REQ_EXEC) ? REG_W'(r_rd) : REG_W'(r_sel);
        ctl.start = 1'b0;
        ctl.op = r_op;
        ctl.imm = r_imm;
        reg_we = '0;
        pc_we = '0;
        unique case (r_state)
            ST_CALC: ctl.start = 1'b1;
            ST_WRITE: begin
                for (int i = 0; i < LANES; i++) begin
                    reg_we[i] = r_mask[i] && rd_ok;
                    pc_we[i] = r_mask[i];
                end
            end
            ST_DONE: begin
                if (r_req == REQ_WRITE && lane_ok) begin
                    for (int i = 0; i < LANES; i++) begin
                        reg_we[i] = (LANE_W'(i) == LANE_W'(r_lane)) && sel_reg_ok;
                        pc_we[i] = (LANE_W'(i) == LANE_W'(r_lane)) &&
                                   (r_sel == 6'(SEL_PC));
                    end
                end
            end
            default: ;
        endcase
        for (int i = 0; i < LANES; i++) begin
            wdata[i] = (r_req == REQ_EXEC) ? res[i] : r_wval;
            pc_wd[i] = (r_req == REQ_EXEC) ? pcs[i] + 32'd4 : r_wval;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        swia_lane_bank u_bank (
            .i_clk, .i_rst_n, .i_ctl(ctl), .i_raddr1(raddr1), .i_raddr2(raddr2),
            .i_a_zero(a_zero), .i_b_zero(b_zero), .i_reg_we(reg_we[g]),
            .i_waddr(waddr), .i_wdata(wdata[g]), .i_pc_we(pc_we[g]),
            .i_pc_wdata(pc_wd[g]), .o_rd1(rd1[g]), .o_pc(pcs[g]),
            .o_result(res[g]), .o_done(done[g]));
    end

    // Merge: the addressed lane's read data.
    logic [31:0] n_rdata;
    always_comb begin
        n_rdata = '0;
        if (r_req == REQ_READ && lane_ok) begin
            if (r_sel == 6'(SEL_PC)) n_rdata = pcs[LANE_W'(r_lane)];
            else if (sel_reg_ok) n_rdata = rd1[LANE_W'(r_lane)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mask <= 32'hFFFF_FFFF;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_mask <= i_cfg_active_mask;
            if (r_state == ST_DONE) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= i_req_type; r_op <= i_op; r_rd <= i_dest_reg;
            r_rs1 <= i_src1_reg; r_rs2 <= i_src2_reg; r_imm <= i_immediate;
            r_lane <= i_lane_sel; r_sel <= i_reg_sel; r_wval <= i_write_value;
        end
        if (r_state == ST_DONE) begin
            r_odata <= n_rdata;
            r_oill <= (r_req == REQ_EXEC) && op_bad;
        end
    end

    assign o_valid = r_ovalid;
    assign o_read_data = r_odata;
    assign o_illegal = r_oill;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready) else $error("accept while busy");
    a_done_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> o_valid) else $error("result lost");
    a_illegal_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_illegal) |-> (o_read_data == '0)) else $error("bad result");
endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the SIMT warp integer ALU, with a lane-state predictor.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import swia_pkg::*;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int PHASE_ITEMS = 150;
    // Registers below this index are loaded in every lane and used by random traffic.
    localparam int LIVE_REGS = 9;

    typedef struct {
        t_req        req;
        t_op         op;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic [4:0]  lane;
        logic [5:0]  sel;
        logic [31:0] wval;
    } t_warp_req;

    typedef struct {
        logic [31:0] rdata;
        logic        bad;
    } t_warp_rsp;

    class t_result_board;
        logic [31:0] mask;
        logic [31:0] gpr[LANES][32];
        logic [31:0] pc[LANES];
        t_warp_rsp   expected_results[$];
        int          errors;
        int          checked;
        int          execs;
        int          div_execs;

        function new();
            mask = '1;
            errors = 0;
            checked = 0;
            execs = 0;
            div_execs = 0;
            foreach (gpr[l, r]) gpr[l][r] = '0;
            foreach (pc[l]) pc[l] = '0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function logic [31:0] lane_alu(t_op op, logic [31:0] a, logic [31:0] b,
                                       logic [31:0] imm, logic [31:0] lane_pc);
            longint sa;
            longint sb;
            longint unsigned ua;
            longint unsigned ub;
            longint prod;
            longint unsigned uprod;
            sa = longint'($signed(a));
            sb = longint'($signed(b));
            ua = {32'b0, a};
            ub = {32'b0, b};
            case (op)
                OP_ADDPC:  return lane_pc + imm;
                OP_ADDI:   return a + imm;
                OP_SLTI:   return {31'b0, $signed(a) < $signed(imm)};
                OP_SLTI_U: return {31'b0, a < imm};
                OP_XORI:   return a ^ imm;
                OP_ORI:    return a | imm;
                OP_ANDI:   return a & imm;
                OP_SLLI:   return a << imm[4:0];
                OP_SRLI:   return a >> imm[4:0];
                OP_SRAI:   return $signed(a) >>> imm[4:0];
                OP_ADD:    return a + b;
                OP_SUB:    return a - b;
                OP_SLL:    return a << b[4:0];
                OP_SLT:    return {31'b0, $signed(a) < $signed(b)};
                OP_SLTU:   return {31'b0, a < b};
                OP_XOR:    return a ^ b;
                OP_SRL:    return a >> b[4:0];
                OP_SRA:    return $signed(a) >>> b[4:0];
                OP_OR:     return a | b;
                OP_AND:    return a & b;
                OP_MUL:    return a * b;
                OP_MULH: begin
                    prod = sa * sb;
                    return prod[63:32];
                end
                OP_MULH_SU: begin
                    prod = sa * longint'(ub);
                    return prod[63:32];
                end
                OP_MULH_UU: begin
                    uprod = ua * ub;
                    return uprod[63:32];
                end
                OP_DIV: begin
                    if (b == 0) return '1;
                    if (a == 32'h8000_0000 && b == '1) return a;
                    prod = sa / sb;
                    return prod[31:0];
                end
                OP_DIVU:   return (b == 0) ? '1 : a / b;
                OP_REM: begin
                    if (b == 0) return a;
                    if (a == 32'h8000_0000 && b == '1) return '0;
                    prod = sa % sb;
                    return prod[31:0];
                end
                default:   return (b == 0) ? a : a % b;
            endcase
        endfunction

        function void note_request(t_warp_req q);
            t_warp_rsp rsp;
            logic [31:0] a;
            logic [31:0] b;
            rsp.rdata = '0;
            rsp.bad = 1'b0;
            case (q.req)
                REQ_EXEC: begin
                    if (q.op >= OP_BAD0) begin
                        rsp.bad = 1'b1;
                    end else begin
                        execs++;
                        if (q.op >= OP_DIV) div_execs++;
                        for (int l = 0; l < LANES; l++) begin
                            if (mask[l]) begin
                                a = gpr[l][q.rs1];
                                b = gpr[l][q.rs2];
                                if (q.rd != 0) gpr[l][q.rd] = lane_alu(q.op, a, b, q.imm, pc[l]);
                                pc[l] = pc[l] + 32'd4;
                            end
                        end
                    end
                end
                REQ_WRITE: begin
                    if (q.sel == SEL_PC) pc[q.lane] = q.wval;
                    else if (q.sel < SEL_PC && q.sel != 0) gpr[q.lane][q.sel[4:0]] = q.wval;
                end
                REQ_READ: begin
                    if (q.sel == SEL_PC) rsp.rdata = pc[q.lane];
                    else if (q.sel < SEL_PC) rsp.rdata = gpr[q.lane][q.sel[4:0]];
                end
                default: ;
            endcase
            expected_results.push_back(rsp);
        endfunction

        function void check_result(logic [31:0] rdata, logic bad);
            t_warp_rsp exp_rsp;
            checked++;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat: read_data=%h illegal=%b",
                                           rdata, bad);
                return;
            end
            exp_rsp = expected_results.pop_front();
            if (rdata !== exp_rsp.rdata || bad !== exp_rsp.bad) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch on result %0d: read_data exp %h got %h, illegal exp %b got %b",
                             checked, exp_rsp.rdata, rdata, exp_rsp.bad, bad);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_active_mask = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_req_type = '0;
    logic [4:0]  i_op = '0;
    logic [4:0]  i_dest_reg = '0;
    logic [4:0]  i_src1_reg = '0;
    logic [4:0]  i_src2_reg = '0;
    logic [31:0] i_immediate = '0;
    logic [4:0]  i_lane_sel = '0;
    logic [5:0]  i_reg_sel = '0;
    logic [31:0] i_write_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_read_data;
    logic        o_illegal;

    t_result_board board = new();
    int  sent_beats = 0;
    int  idle_cycles = 0;
    bit  no_idling = 1'b0;
    bit  hold_done = 1'b0;

    simt_warp_integer_alu dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_active_mask(i_cfg_active_mask),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_req_type(i_req_type), .i_op(i_op), .i_dest_reg(i_dest_reg),
        .i_src1_reg(i_src1_reg), .i_src2_reg(i_src2_reg), .i_immediate(i_immediate),
        .i_lane_sel(i_lane_sel), .i_reg_sel(i_reg_sel), .i_write_value(i_write_value),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_read_data(o_read_data), .o_illegal(o_illegal)
    );

    always #4 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idling || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Operand values lean toward the corners that trip up dividers and comparators.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h1;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_req(t_warp_req q);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= q.req;
        i_op <= q.op;
        i_dest_reg <= q.rd;
        i_src1_reg <= q.rs1;
        i_src2_reg <= q.rs2;
        i_immediate <= q.imm;
        i_lane_sel <= q.lane;
        i_reg_sel <= q.sel;
        i_write_value <= q.wval;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_request(q);
        sent_beats++;
    endtask

    task automatic lane_write(int lane, int sel, logic [31:0] v);
        t_warp_req q;
        q = '{REQ_WRITE, t_op'($urandom_range(0, 31)), 5'($urandom()), 5'($urandom()),
              5'($urandom()), $urandom(), 5'(lane), 6'(sel), v};
        send_req(q);
    endtask

    task automatic lane_read(int lane, int sel);
        t_warp_req q;
        q = '{REQ_READ, t_op'($urandom_range(0, 31)), 5'($urandom()), 5'($urandom()),
              5'($urandom()), $urandom(), 5'(lane), 6'(sel), $urandom()};
        send_req(q);
    endtask

    task automatic lane_exec(t_op op, int rd, int rs1, int rs2, logic [31:0] imm);
        t_warp_req q;
        q = '{REQ_EXEC, op, 5'(rd), 5'(rs1), 5'(rs2), imm, 5'($urandom()),
              6'($urandom()), $urandom()};
        send_req(q);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_mask(logic [31:0] m);
        i_cfg_valid <= 1'b1;
        i_cfg_active_mask <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.mask = m;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        t_warp_req q;
        int r;
        int s;
        for (int k = 0; k < n; k++) begin
            q = '{REQ_EXEC, t_op'($urandom_range(0, 27)), 5'($urandom_range(0, LIVE_REGS - 1)),
                  5'($urandom_range(0, LIVE_REGS - 1)), 5'($urandom_range(0, LIVE_REGS - 1)),
                  pick_value(), 5'($urandom()), 6'($urandom_range(0, LIVE_REGS - 1)),
                  pick_value()};
            r = $urandom_range(0, 99);
            if (r < 5) q.op = t_op'($urandom_range(28, 31));
            else if (r < 25) q.req = REQ_WRITE;
            else if (r < 50) q.req = REQ_READ;
            else if (r < 55) q.req = REQ_NONE;
            // Reads and writes hit loaded registers, the counter, or indices past it.
            s = $urandom_range(0, 3);
            if (s == 0) q.sel = 6'($urandom_range(SEL_PC + 1, 63));
            else if (s == 1) q.sel = 6'(SEL_PC);
            send_req(q);
        end
    endtask

    // Result side: random stalls, plus one long hold-off that backs up the input.
    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!hold_done && sent_beats >= 600) begin
                hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (600) @(posedge i_clk);
            end
            stall = pick_gap();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) board.check_result(o_read_data, o_illegal);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((o_valid && i_ready) || (i_valid && o_ready) || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("timeout with %0d results outstanding", board.pending());
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] masks[6];
        masks = '{32'hFFFF_FFFF, 32'h0, 32'h1, 32'h8000_0000, $urandom(), $urandom()};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Load the working registers and the counter of every lane so nothing
        // undefined is ever read.
        for (int l = 0; l < LANES; l++) begin
            for (int r = 1; r < LIVE_REGS; r++) lane_write(l, r, pick_value());
            lane_write(l, SEL_PC, pick_value());
        end

        // Directed corners, mostly in lane 0.
        lane_write(0, 5, 32'h8000_0000);
        lane_write(0, 6, 32'hFFFF_FFFF);
        lane_write(0, 7, 32'h0);
        lane_write(0, 0, 32'hDEAD_BEEF);
        lane_read(0, 0);
        lane_exec(OP_DIV, 9, 5, 6, '0);
        lane_exec(OP_REM, 10, 5, 6, '0);
        lane_exec(OP_DIV, 11, 8, 7, '0);
        lane_exec(OP_DIVU, 12, 8, 7, '0);
        lane_exec(OP_REM, 13, 8, 7, '0);
        lane_exec(OP_REMU, 14, 8, 7, '0);
        lane_exec(OP_MULH, 15, 5, 5, '0);
        lane_exec(OP_MULH_SU, 16, 5, 6, '0);
        lane_exec(OP_ADDI, 17, 0, 3, 32'h1234_5000);
        lane_exec(OP_ADDPC, 18, 1, 2, 32'hFFFF_F000);
        lane_exec(OP_ADD, 0, 5, 6, '0);
        lane_exec(OP_BAD0, 19, 5, 6, '0);
        lane_exec(OP_BAD3, 19, 5, 6, '1);
        lane_read(0, 9);
        lane_read(0, 10);
        lane_read(31, SEL_PC);
        lane_read(3, 33);
        lane_write(3, 63, 32'h5555_AAAA);
        lane_read(3, 63);
        send_req('{REQ_NONE, OP_ADD, 5'd1, 5'd2, 5'd3, '1, 5'd4, 6'd5, '1});
        drain();

        for (int p = 0; p < 6; p++) begin
            set_mask(masks[p]);
            no_idling = (p == 2);
            random_phase(PHASE_ITEMS);
            drain();
        end

        $display("%0d beats checked, %0d executes (%0d divides) over 6 lane masks",
                 board.checked, board.execs, board.div_execs);
        $display("mismatches: %0d", board.errors);
        if (board.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
